### design/inet_csum_pkg.sv
package inet_csum_pkg;

    typedef logic [15:0] word_t;
    typedef logic [7:0]  byte_t;

    localparam int unsigned CFG_DATA_W = 32;
    localparam byte_t       PROTO_RESET = 8'd6;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_SRC   = 2'd1,
        CFG_DST   = 2'd2,
        CFG_PROTO = 2'd3
    } cfg_index_t;

    // One's complement add of two words, end-around carry.
    function automatic word_t csum_add2(input word_t a, input word_t b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // One's complement add of three words, folded twice.
    function automatic word_t csum_add3(input word_t a, input word_t b, input word_t c);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'd0, a} + {2'd0, b} + {2'd0, c};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

    // One's complement add of five words, folded twice.
    function automatic word_t csum_add5(input word_t a, input word_t b, input word_t c,
                                        input word_t d, input word_t e);
        logic [18:0] s;
        logic [16:0] f;
        s = {3'd0, a} + {3'd0, b} + {3'd0, c} + {3'd0, d} + {3'd0, e};
        f = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

### design/internet_checksum_stream_top.sv
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+-----------------------------------------
// s_ input  | in  | s_tvalid / s_tready | s_tdata[7:0] = data_byte, s_tlast = last_byte
// m_ result | out | m_tvalid / m_tready | m_tdata[15:0] = checksum_value
// cfg write | in  | cfg_wr_en           | cfg_index[1:0], cfg_wdata[31:0]
//
// One byte item is taken per cycle while s_tready is high; the running sum loop is a
// single 16-bit end-around add. A result goes from its last byte through one finish
// stage (pseudo-header base and length added in that mode), then the output register.
// Reset (aresetn low at a clock edge) clears packet state, drops pending results
// and restores register defaults (protocol 6, everything else 0).
// A stalled result only blocks input once the finish stage is also full.
module internet_checksum_stream_top
    import inet_csum_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] checksum_value

    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers and the precomputed pseudo-header base
    logic        mode_reg,  mode_next;
    logic [31:0] src_reg,   src_next;
    logic [31:0] dst_reg,   dst_next;
    byte_t       proto_reg, proto_next;
    word_t       pbase_reg, pbase_next;

    // Packet accumulation state
    word_t       running_sum_reg;
    logic        odd_phase_reg;
    byte_t       held_high_byte_reg;
    word_t       byte_count_reg;

    // Finish stage
    logic        fin_valid_reg;
    word_t       fin_sum_reg;
    word_t       fin_count_reg;

    // Output register
    logic        out_valid_reg;
    word_t       out_data_reg;

    logic        s_accept;
    logic        out_free;
    logic        fin_free;
    logic        add_en;
    word_t       word_in;
    word_t       sum_next;
    word_t       count_next;
    word_t       fin_result;

    // Next register values, so the base tracks a write at the same edge.
    always_comb begin
        mode_next  = mode_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        proto_next = proto_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:  mode_next  = cfg_wdata[0];
                CFG_SRC:   src_next   = cfg_wdata[31:0];
                CFG_DST:   dst_next   = cfg_wdata[31:0];
                CFG_PROTO: proto_next = cfg_wdata[7:0];
                default:   mode_next  = mode_reg;
            endcase
        end
        pbase_next = csum_add5(src_next[31:16], src_next[15:0],
                               dst_next[31:16], dst_next[15:0],
                               {8'd0, proto_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            src_reg   <= '0;
            dst_reg   <= '0;
            proto_reg <= PROTO_RESET;
            pbase_reg <= {8'd0, PROTO_RESET};
        end else begin
            mode_reg  <= mode_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            proto_reg <= proto_next;
            pbase_reg <= pbase_next;
        end
    end

    // Handshake: advance the finish stage whenever the output register can take it
    assign out_free = !out_valid_reg || m_tready;
    assign fin_free = !fin_valid_reg || out_free;
    assign s_tready = fin_free;
    assign s_accept = s_tvalid && s_tready;

    // Pair bytes big-endian; a lone last byte goes in as the high byte.
    assign add_en     = odd_phase_reg || s_tlast;
    assign word_in    = odd_phase_reg ? {held_high_byte_reg, s_tdata} : {s_tdata, 8'h00};
    assign sum_next   = add_en ? csum_add2(running_sum_reg, word_in) : running_sum_reg;
    assign count_next = byte_count_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg    <= '0;
            odd_phase_reg      <= 1'b0;
            held_high_byte_reg <= '0;
            byte_count_reg     <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                // Packet done: clear for the next one
                running_sum_reg    <= '0;
                odd_phase_reg      <= 1'b0;
                held_high_byte_reg <= '0;
                byte_count_reg     <= '0;
            end else begin
                running_sum_reg    <= sum_next;
                odd_phase_reg      <= !odd_phase_reg;
                held_high_byte_reg <= odd_phase_reg ? 8'h00 : s_tdata;
                byte_count_reg     <= count_next;
            end
        end
    end

    // Finish stage: hold the packet sum and length until the output takes them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_free) begin
            fin_valid_reg <= s_accept && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_free && s_accept && s_tlast) begin
            fin_sum_reg   <= sum_next;
            fin_count_reg <= count_next;
        end
    end

    // Pseudo-header mode folds in addresses, protocol and length.
    assign fin_result = mode_reg ? ~csum_add3(fin_sum_reg, pbase_reg, fin_count_reg)
                                 : ~fin_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && fin_valid_reg) begin
            out_data_reg <= fin_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A last byte always lands in the finish stage and clears the packet state.
    a_last_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> fin_valid_reg)
        else $error("last item did not reach finish stage");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=>
            (running_sum_reg == 16'd0 && !odd_phase_reg && byte_count_reg == 16'd0))
        else $error("packet state not cleared after last item");

    a_held_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !odd_phase_reg |-> held_high_byte_reg == 8'h00)
        else $error("held byte set outside odd phase");

    a_fin_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid_reg && out_free) |=> out_valid_reg)
        else $error("finished result lost between stages");

    a_odd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        odd_phase_reg |-> byte_count_reg[0])
        else $error("odd phase disagrees with byte count");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import inet_csum_pkg::*;

    // Consecutive cycles with no item moving on either side before the run is
    // called hung. The longest legitimate quiet stretch is a few sender and
    // receiver gaps plus the trip through the result pipeline and a settle pause.
    localparam int unsigned HANG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS = 58;
    localparam int unsigned DIR_N = 19;

    typedef struct packed {
        byte_t data;
        logic  last;
        logic  known;   // want holds a hand-computed checksum
        word_t want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;    // [7:0] data_byte
    logic                  s_tlast = 1'b0;  // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] checksum_value
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copies, at their reset values
    logic        hdr_en = 1'b0;
    logic [31:0] hdr_src = '0;
    logic [31:0] hdr_dst = '0;
    byte_t       hdr_proto = PROTO_RESET;

    // Packet accumulation state of the predictor
    word_t acc_sum = '0;
    logic  acc_odd = 1'b0;
    byte_t acc_hi = '0;
    word_t acc_len = '0;

    word_t       checksum_q[$];
    int unsigned error_cnt = 0;
    int unsigned idle_cycles = 0;
    logic        no_idle = 1'b0;

    // Directed items, run at reset register values (plain checksum).
    // Rows with known set carry a checksum worked out by hand.
    dir_row_t dir_tbl [DIR_N] = '{
        {8'h00, 1'b1, 1'b1, 16'hFFFF},  // all-zero sum right after reset
        {8'hFF, 1'b1, 1'b1, 16'h00FF},  // lone byte padded with a zero low byte
        {8'hFF, 1'b0, 1'b0, 16'h0000},
        {8'hFF, 1'b1, 1'b1, 16'h0000},  // full word of ones
        {8'h12, 1'b0, 1'b0, 16'h0000},
        {8'h34, 1'b1, 1'b0, 16'h0000},
        {8'h01, 1'b0, 1'b0, 16'h0000},  // odd length, padded tail
        {8'h02, 1'b0, 1'b0, 16'h0000},
        {8'h03, 1'b1, 1'b0, 16'h0000},
        {8'hFF, 1'b0, 1'b0, 16'h0000},  // end-around carry twice
        {8'hFF, 1'b0, 1'b0, 16'h0000},
        {8'hFF, 1'b0, 1'b0, 16'h0000},
        {8'hFF, 1'b0, 1'b0, 16'h0000},
        {8'h00, 1'b0, 1'b0, 16'h0000},
        {8'h01, 1'b1, 1'b0, 16'h0000},
        {8'h80, 1'b0, 1'b0, 16'h0000},  // carry out of the top bit
        {8'h00, 1'b0, 1'b0, 16'h0000},
        {8'h80, 1'b0, 1'b0, 16'h0000},
        {8'h00, 1'b1, 1'b0, 16'h0000}
    };

    internet_checksum_stream_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One's complement add with end-around carry
    function automatic word_t fold_add(input word_t a, input word_t b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // Lean toward all-zero and all-one bytes to exercise carries
    function automatic byte_t rand_byte();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) begin
            return 8'h00;
        end else if (k == 1) begin
            return 8'hFF;
        end
        return byte_t'($urandom());
    endfunction

    // Advance the predicted packet state by one byte; on the last byte
    // produce the checksum and clear the packet state.
    task automatic account_byte(input byte_t d, input logic last,
                                output logic done, output word_t csum);
        word_t sum;
        sum = acc_sum;
        acc_len = acc_len + 16'd1;
        done = 1'b0;
        csum = '0;
        if (acc_odd) begin
            sum = fold_add(sum, {acc_hi, d});
            acc_odd = 1'b0;
            acc_hi = '0;
        end else if (last) begin
            sum = fold_add(sum, {d, 8'h00});
        end else begin
            acc_hi = d;
            acc_odd = 1'b1;
        end
        if (!last) begin
            acc_sum = sum;
        end else begin
            if (hdr_en) begin
                sum = fold_add(sum, hdr_src[31:16]);
                sum = fold_add(sum, hdr_src[15:0]);
                sum = fold_add(sum, hdr_dst[31:16]);
                sum = fold_add(sum, hdr_dst[15:0]);
                sum = fold_add(sum, {8'h00, hdr_proto});
                sum = fold_add(sum, acc_len);
            end
            csum = ~sum;
            done = 1'b1;
            acc_sum = '0;
            acc_odd = 1'b0;
            acc_hi = '0;
            acc_len = '0;
        end
    endtask

    // Present one byte after a random gap and hold it until accepted.
    // Valid stays high straight into the next item when its gap is zero.
    task automatic send_byte(input byte_t d, input logic last,
                             input logic known, input word_t want);
        int unsigned gap;
        logic        done;
        word_t       csum;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        account_byte(d, last, done, csum);
        if (done) begin
            checksum_q.push_back(known ? want : csum);
        end
    endtask

    task automatic send_packet(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte(rand_byte(), i == n - 1, 1'b0, '0);
        end
    endtask

    // Hold off the sender until every checksum has come out, then let the
    // result pipeline drain before touching the registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; the caller drops the write enable after the burst
    task automatic reg_write(input cfg_index_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_MODE:  hdr_en = val[0];
            CFG_SRC:   hdr_src = val;
            CFG_DST:   hdr_dst = val;
            CFG_PROTO: hdr_proto = val[7:0];
            default: ;
        endcase
    endtask

    // Write all four registers; junk above the narrow fields must be dropped
    task automatic apply_setting(input logic mode, input logic [31:0] src,
                                 input logic [31:0] dst, input byte_t proto);
        reg_write(CFG_MODE,  ($urandom() & 32'hFFFF_FFFE) | {31'd0, mode});
        reg_write(CFG_SRC,   src);
        reg_write(CFG_DST,   dst);
        reg_write(CFG_PROTO, ($urandom() & 32'hFFFF_FF00) | {24'd0, proto});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned rand_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom_range(1, 8);
        end else if (r < 9) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(41, 120);
    endfunction

    // Receiver: after each result, drop ready for a random number of cycles,
    // then hold it high until the next result is taken. Compare every result
    // against the oldest outstanding checksum.
    always @(posedge aclk) begin : result_sink
        int unsigned g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (checksum_q.size() == 0) begin
                $error("checksum_value: unexpected result %h", m_tdata);
                error_cnt++;
            end else if (m_tdata !== checksum_q[0]) begin
                $error("checksum_value mismatch: expected %h, actual %h",
                       checksum_q[0], m_tdata);
                error_cnt++;
                void'(checksum_q.pop_front());
            end else begin
                void'(checksum_q.pop_front());
            end
            g = draw_gap();
            m_tready <= (g == 0);
            if (g != 0) begin
                fork
                    begin
                        repeat (g) @(posedge aclk);
                        m_tready <= 1'b1;
                    end
                join_none
            end
        end
    end

    // Bring ready up once after reset; the sink takes over from there
    initial begin
        @(posedge aclk iff aresetn);
        m_tready <= 1'b1;
    end

    // Watchdog: count cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at reset register values
        foreach (dir_tbl[i]) begin
            send_byte(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].known, dir_tbl[i].want);
        end
        settle();

        // Switch on the pseudo-header alone: addresses stay zero, protocol at its
        // reset value
        reg_write(CFG_MODE, ($urandom() & 32'hFFFF_FFFE) | 32'd1);
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 4; i++) begin
            send_packet(rand_len());
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            int unsigned sent;
            settle();
            case (ph)
                0: apply_setting(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
                1: apply_setting(1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00);
                2: apply_setting(1'b0, $urandom(), $urandom(), byte_t'($urandom()));
                default: apply_setting(1'($urandom()), $urandom(), $urandom(),
                                       byte_t'($urandom()));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                int unsigned n;
                n = rand_len();
                no_idle = ($urandom_range(0, 5) == 0);
                send_packet(n);
                sent += n;
                // Now and then hold the sender until every checksum is out
                if ($urandom_range(0, 11) == 0) begin
                    settle();
                end
            end
            no_idle = 1'b0;
        end

        // Drain, then keep watching for any stray result
        s_tvalid <= 1'b0;
        while (checksum_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
design/inet_csum_pkg.sv
design/internet_checksum_stream_top.sv
tb/tb.sv
